// File: design/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication that stays active through reset.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: design/ifr_pkg.sv
`timescale 1ns / 1ps

package ifr_pkg;

   localparam logic [7:0] FLAG_BYTE = 8'h7E;
   localparam logic [7:0] ESC_BYTE  = 8'h7D;
   localparam logic [7:0] CTRL_ACK  = 8'h05;
   localparam logic [7:0] CTRL_NACK = 8'h01;

   localparam logic [1:0] VERDICT_NEW = 2'd0;
   localparam logic [1:0] VERDICT_DUP = 2'd1;
   localparam logic [1:0] VERDICT_REJ = 2'd2;

   localparam logic [7:0] REG_MAX_FRAME = 8'd0;
   localparam logic [7:0] REG_ADDRESS   = 8'd1;

   localparam int RSP_DATA_W = 32;

   // Reply run: flag, address, control, header check, flag.
   localparam logic [2:0] REPLY_LAST_IDX = 3'd4;

   // What one accepted line byte asks of the output side.
   typedef struct packed {
      logic        payload;   // deliver data as a payload byte
      logic        reply;     // emit the five-byte reply run
      logic [7:0]  data;
      logic [7:0]  addr;
      logic [7:0]  ctrl;
      logic [1:0]  verdict;
      logic [15:0] count;
   } event_type;

endpackage

// File: design/ifr_parser.sv
`timescale 1ns / 1ps

module ifr_parser #(
   parameter int COUNT_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_accept,
   input  logic [7:0]           rx_byte,
   input  logic [15:0]          max_frame_bytes,
   input  logic [7:0]           address_byte,
   output ifr_pkg::event_type   evt
);

   localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

   localparam logic [2:0] ST_START    = 3'd0;
   localparam logic [2:0] ST_FLAG     = 3'd1;
   localparam logic [2:0] ST_ADDR     = 3'd2;
   localparam logic [2:0] ST_CTRL_NEW = 3'd3;
   localparam logic [2:0] ST_CTRL_OLD = 3'd4;
   localparam logic [2:0] ST_DATA     = 3'd5;
   localparam logic [2:0] ST_SKIP     = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic                  seq_ff, seq_in;
   logic                  esc_ff, esc_in;
   logic [7:0]            xor_ff, xor_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [7:0]            held_byte_ff, held_byte_in;
   logic                  held_valid_ff, held_valid_in;

   logic [7:0]       c_new;
   logic [7:0]       c_old;
   logic [7:0]       c_hdr;
   logic             is_flag;
   logic             is_esc;
   logic             clear;
   logic [CMP_W-1:0] cnt_wide;
   logic [CMP_W-1:0] max_wide;
   logic [CMP_W-1:0] dlv_wide;
   logic [15:0]      delivered;
   logic             overflow;

   assign c_new    = {1'b0, seq_ff, 6'b0};
   assign c_old    = {1'b0, ~seq_ff, 6'b0};
   assign c_hdr    = (state_ff == ST_CTRL_NEW) ? c_new : c_old;
   assign is_flag  = (rx_byte == ifr_pkg::FLAG_BYTE);
   assign is_esc   = (rx_byte == ifr_pkg::ESC_BYTE);
   assign cnt_wide = CMP_W'(cnt_ff);
   assign max_wide = CMP_W'(max_frame_bytes);
   assign dlv_wide = cnt_wide - CMP_W'(1);
   // The held byte is the check byte, so it is not counted as delivered.
   assign delivered = (cnt_ff == '0) ? 16'd0 : dlv_wide[15:0];
   assign overflow  = (cnt_wide >= max_wide) || (cnt_ff == '1);

   always_comb begin
      state_in      = state_ff;
      seq_in        = seq_ff;
      esc_in        = esc_ff;
      xor_in        = xor_ff;
      cnt_in        = cnt_ff;
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      clear         = 1'b0;
      evt           = '0;
      evt.data      = held_byte_ff;
      evt.addr      = address_byte;
      case (state_ff)
         ST_FLAG: begin
            if (is_flag) state_in = ST_FLAG;
            else if (rx_byte == address_byte) state_in = ST_ADDR;
            else state_in = ST_START;
         end
         ST_ADDR: begin
            if (is_flag) state_in = ST_FLAG;
            else if (rx_byte == c_new) state_in = ST_CTRL_NEW;
            else if (rx_byte == c_old) state_in = ST_CTRL_OLD;
            else state_in = ST_START;
         end
         ST_CTRL_NEW, ST_CTRL_OLD: begin
            if (is_flag) begin
               state_in = ST_FLAG;
            end else if (rx_byte == (address_byte ^ c_hdr)) begin
               state_in = (state_ff == ST_CTRL_NEW) ? ST_DATA : ST_SKIP;
               clear    = 1'b1;
            end else begin
               state_in = ST_START;
            end
         end
         ST_SKIP: begin
            if (!esc_ff && is_flag) begin
               evt.reply   = 1'b1;
               evt.ctrl    = {seq_ff, ifr_pkg::CTRL_ACK[6:0]};
               evt.verdict = ifr_pkg::VERDICT_DUP;
               state_in    = ST_START;
               clear       = 1'b1;
            end else begin
               esc_in = !esc_ff && is_esc;
            end
         end
         ST_DATA: begin
            if (!esc_ff && is_flag) begin
               evt.reply = 1'b1;
               state_in  = ST_START;
               clear     = 1'b1;
               if (!held_valid_ff || cnt_ff == '0) begin
                  evt.ctrl    = {seq_ff, ifr_pkg::CTRL_NACK[6:0]};
                  evt.verdict = ifr_pkg::VERDICT_REJ;
               end else if (xor_ff == 8'd0) begin
                  // XOR over payload and check byte is zero for a good frame.
                  evt.ctrl    = {~seq_ff, ifr_pkg::CTRL_ACK[6:0]};
                  evt.verdict = ifr_pkg::VERDICT_NEW;
                  evt.count   = delivered;
                  seq_in      = ~seq_ff;
               end else begin
                  evt.ctrl    = {seq_ff, ifr_pkg::CTRL_NACK[6:0]};
                  evt.verdict = ifr_pkg::VERDICT_REJ;
                  evt.count   = delivered;
               end
            end else if (!esc_ff && is_esc) begin
               esc_in = 1'b1;
            end else begin
               esc_in = 1'b0;
               if (overflow) begin
                  evt.reply   = 1'b1;
                  evt.ctrl    = {seq_ff, ifr_pkg::CTRL_NACK[6:0]};
                  evt.verdict = ifr_pkg::VERDICT_REJ;
                  evt.count   = delivered;
                  state_in    = ST_START;
                  clear       = 1'b1;
               end else begin
                  evt.payload   = held_valid_ff;
                  xor_in        = xor_ff ^ rx_byte;
                  held_byte_in  = rx_byte;
                  held_valid_in = 1'b1;
                  cnt_in        = cnt_ff + COUNT_BITS'(1);
               end
            end
         end
         default: begin
            state_in = is_flag ? ST_FLAG : ST_START;
         end
      endcase
      if (clear) begin
         esc_in        = 1'b0;
         xor_in        = 8'd0;
         cnt_in        = '0;
         held_byte_in  = 8'd0;
         held_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_START;
         seq_ff        <= 1'b0;
         esc_ff        <= 1'b0;
         xor_ff        <= 8'd0;
         cnt_ff        <= '0;
         held_valid_ff <= 1'b0;
      end else if (in_accept) begin
         state_ff      <= state_in;
         seq_ff        <= seq_in;
         esc_ff        <= esc_in;
         xor_ff        <= xor_in;
         cnt_ff        <= cnt_in;
         held_valid_ff <= held_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_byte_ff <= 8'd0;
      end else if (in_accept) begin
         held_byte_ff <= held_byte_in;
      end
   end

endmodule

// File: design/ifr_reply_seq.sv
`timescale 1ns / 1ps

module ifr_reply_seq (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  ifr_pkg::event_type              evt,
   output logic                            can_load,
   input  logic                            rsp_tready,
   output logic                            rsp_tvalid,
   output logic [ifr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tlast,
   output logic                            rsp_tuser
);

   logic               busy_ff, busy_in;
   logic [2:0]         idx_ff, idx_in;
   ifr_pkg::event_type evt_ff;
   logic               done;
   logic [7:0]         out_byte;
   logic [1:0]         verdict;
   logic [15:0]        count;

   assign done     = busy_ff && rsp_tready &&
                     (!evt_ff.reply || idx_ff == ifr_pkg::REPLY_LAST_IDX);
   assign can_load = !busy_ff || done;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in  = 3'd0;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff && rsp_tready) begin
         idx_in = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) evt_ff <= evt;
   end

   always_comb begin
      case (idx_ff)
         3'd0:    out_byte = ifr_pkg::FLAG_BYTE;
         3'd1:    out_byte = evt_ff.addr;
         3'd2:    out_byte = evt_ff.ctrl;
         3'd3:    out_byte = evt_ff.addr ^ evt_ff.ctrl;
         default: out_byte = ifr_pkg::FLAG_BYTE;
      endcase
      if (!evt_ff.reply) out_byte = evt_ff.data;
      verdict = evt_ff.reply ? evt_ff.verdict : 2'd0;
      count   = evt_ff.reply ? evt_ff.count : 16'd0;
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tuser  = evt_ff.reply;
   assign rsp_tlast  = evt_ff.reply && (idx_ff == ifr_pkg::REPLY_LAST_IDX);
   assign rsp_tdata  = {6'd0, count, verdict, out_byte};

endmodule

// File: design/info_frame_receiver_top.sv
`timescale 1ns / 1ps

// Receiver for stop-and-wait information frames. Line bytes enter on req_ at up to one
// per clock; each one is parsed in the cycle it is accepted, and a byte that yields a
// result loads it into the output register at that same edge. A payload byte leaves one
// byte late, so the trailing check byte is never shown. A byte that ends a frame (or
// overflows it) yields a five-byte ACK or NACK run on rsp_. req_tready is low whenever
// the output register holds a result that cannot leave in the current cycle, so a result
// held by rsp_tready low stalls every input byte. With rsp_tready high a payload result
// leaves in the next cycle and bytes keep flowing without a gap, while a reply run keeps
// req_tready low while it shows its first four bytes and lets it rise with the fifth.
// The user must write registers on csr_ only while the block is idle; the block does
// not enforce this. csr_ready is always high.
module info_frame_receiver_top #(
   parameter int COUNT_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata: rx_byte[7:0]
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,
   // rsp_tdata: out_byte[7:0], frame_verdict[9:8], payload_count[25:10], zero fill
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ifr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tlast,
   // rsp_tuser: out_kind[0]
   output logic                            rsp_tuser,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [7:0]                      csr_index,
   input  logic [15:0]                     csr_data
);

   logic [15:0]        max_frame_ff;
   logic [7:0]         address_ff;
   logic               in_accept;
   logic               can_load;
   logic               load;
   ifr_pkg::event_type evt;

   assign csr_ready  = 1'b1;
   assign req_tready = can_load;
   assign in_accept  = req_tvalid && req_tready;
   assign load       = in_accept && (evt.payload || evt.reply);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_ff <= 16'd10000;
         address_ff   <= 8'd3;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ifr_pkg::REG_MAX_FRAME: max_frame_ff <= csr_data;
            ifr_pkg::REG_ADDRESS:   address_ff   <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   ifr_parser #(
      .COUNT_BITS(COUNT_BITS)
   ) u_parser (
      .clock           (clock),
      .reset           (reset),
      .in_accept       (in_accept),
      .rx_byte         (req_tdata),
      .max_frame_bytes (max_frame_ff),
      .address_byte    (address_ff),
      .evt             (evt)
   );

   ifr_reply_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .evt        (evt),
      .can_load   (can_load),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: design/ifr_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ifr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [ifr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                            rsp_tlast,
   input logic                            rsp_tuser
);

   // Only reply bytes close a run.
   `ASSERT_IMPL(a_last_is_reply, clock, reset, rsp_tvalid && rsp_tlast, rsp_tuser)

   // Payload bytes carry no verdict or count.
   `ASSERT_IMPL(a_payload_clean, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata[25:8] == 18'd0)

   // A reply run closes with a flag byte.
   `ASSERT_IMPL(a_last_flag, clock, reset, rsp_tvalid && rsp_tlast, rsp_tdata[7:0] == ifr_pkg::FLAG_BYTE)

   // A stalled result transaction holds.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // Reset empties the output register.
   `ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid)

endmodule

bind info_frame_receiver_top ifr_checker u_ifr_checker (.*);
